// ===== rtl/aes128_block_cipher_core_defines.svh =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_core_defines
// Assertion macros shared by the AES-128 core.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES128_BLOCK_CIPHER_CORE_DEFINES_SVH

// Implication checked at every edge out of reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and GF(2^8) helpers for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWords  = 4 * (NumRounds + 1);

  localparam logic [0:0] CMD_ENCRYPT = 1'b0;
  localparam logic [0:0] CMD_DECRYPT = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1b;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // take a new block
    logic first;      // apply the first round key
    logic round;      // run one full middle round
    logic last;       // run the final round into the result register
    logic kx_start;   // begin key expansion
    logic kx_step;    // produce one expanded word
  } aes_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] t;
    acc = 8'h00;
    t   = a;
    for (int n = 0; n < 4; n++) begin
      if (b[n]) acc = acc ^ t;
      t = xtime(t);
    end
    gmul = acc;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

endpackage

// ===== rtl/aes_stream_if.sv =====
// ----------------------------------------------------------------------------
// aes_in_if / aes_out_if
// Valid/ready channels carrying AES requests and results.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, command, block_high, block_low, input ready);
  modport sink   (input valid, command, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

// ===== rtl/aes_datapath.sv =====
// ----------------------------------------------------------------------------
// aes_datapath
// State register, one-round logic, key expansion, round-key memory and the
// result register.
// ----------------------------------------------------------------------------
module aes_datapath #(
  parameter int NUM_ROUNDS = aes_pkg::NumRounds
) (
  input  logic                                       clk,
  input  aes_pkg::aes_cmd_t                          cmd,
  input  logic                                       command,
  input  logic [127:0]                               block_in,
  input  logic [127:0]                               key_in,
  input  logic [$clog2(4*(NUM_ROUNDS+1))-1:0]        kx_idx,
  input  logic [$clog2(NUM_ROUNDS+1)-1:0]            rk_sel,
  output logic [127:0]                               result
);

  localparam int NumWords = 4 * (NUM_ROUNDS + 1);
  localparam int WordIdxW = $clog2(NumWords);
  localparam int RoundW   = $clog2(NUM_ROUNDS + 1);

  // Round keys, stored as one 128-bit row per round, read synchronously.
  logic [127:0] rk_mem [NUM_ROUNDS+1];
  logic [127:0] rk_q;
  logic [127:0] state;
  logic         decrypt;

  // Key expansion: a 4-word sliding window; one word per cycle.
  logic [127:0] win;
  logic [7:0]   rcon;
  logic [31:0]  kx_word;
  logic [31:0]  kx_t;
  logic [127:0] win_next;

  always_comb begin
    kx_t = win[31:0];
    if (kx_idx[1:0] == 2'd0) begin
      kx_t = {aes_pkg::sbox(kx_t[23:16]), aes_pkg::sbox(kx_t[15:8]),
              aes_pkg::sbox(kx_t[7:0]),   aes_pkg::sbox(kx_t[31:24])} ^ {rcon, 24'h0};
    end
    kx_word  = win[127:96] ^ kx_t;
    win_next = {win[95:0], kx_word};
  end

  always_ff @(posedge clk) begin
    if (cmd.kx_start) begin
      win  <= key_in;
      rcon <= 8'h01;
      rk_mem[0] <= key_in;
    end else if (cmd.kx_step) begin
      win <= win_next;
      if (kx_idx[1:0] == 2'd0) rcon <= aes_pkg::xtime(rcon);
      if (kx_idx[1:0] == 2'd3) rk_mem[RoundW'(kx_idx[WordIdxW-1:2])] <= win_next;
    end
    rk_q <= rk_mem[rk_sel];
  end

  // One round, forward or inverse; byte n of the state is bits 127-8n.
  function automatic logic [7:0] sb(input logic [127:0] s, input int n);
    sb = s[127-8*n -: 8];
  endfunction

  logic [127:0] sr_fwd, sr_inv, sub_fwd, sub_inv, mc_fwd, mc_inv, rnd_fwd, rnd_inv;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_fwd[127-8*(c*4+r) -: 8] =
          aes_pkg::sbox(sb(state, ((c + r) & 3) * 4 + r));
        sr_inv[127-8*(((c + r) & 3) * 4 + r) -: 8] = sb(state, c*4 + r);
      end
    end
    for (int n = 0; n < 16; n++) sub_inv[127-8*n -: 8] = aes_pkg::inv_sbox(sb(sr_inv, n));
    sr_fwd = sub_fwd;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mc_fwd[127-8*(c*4+r) -: 8] =
          aes_pkg::gmul(sb(sr_fwd, c*4 + r), 8'h02) ^
          aes_pkg::gmul(sb(sr_fwd, c*4 + ((r+1)&3)), 8'h03) ^
          sb(sr_fwd, c*4 + ((r+2)&3)) ^ sb(sr_fwd, c*4 + ((r+3)&3));
      end
    end
    rnd_inv = sub_inv ^ rk_q;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mc_inv[127-8*(c*4+r) -: 8] =
          aes_pkg::gmul(sb(rnd_inv, c*4 + r), 8'h0e) ^
          aes_pkg::gmul(sb(rnd_inv, c*4 + ((r+1)&3)), 8'h0b) ^
          aes_pkg::gmul(sb(rnd_inv, c*4 + ((r+2)&3)), 8'h0d) ^
          aes_pkg::gmul(sb(rnd_inv, c*4 + ((r+3)&3)), 8'h09);
      end
    end
    rnd_fwd = mc_fwd ^ rk_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state   <= block_in;
      decrypt <= command;
    end else if (cmd.first) begin
      state <= state ^ rk_q;
    end else if (cmd.round) begin
      state <= decrypt ? mc_inv : rnd_fwd;
    end
    // Final round lands in its own register so the next block can start.
    if (cmd.last) result <= decrypt ? rnd_inv : (sr_fwd ^ rk_q);
  end

endmodule

// ===== rtl/aes_ctrl.sv =====
// ----------------------------------------------------------------------------
// aes_ctrl
// Sequencer for key expansion and the round loop, and the result valid flag.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_core_defines.svh"

module aes_ctrl #(
  parameter int NUM_ROUNDS = aes_pkg::NumRounds
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 key_write,
  input  logic                                 in_valid,
  input  logic                                 in_command,
  output logic                                 in_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output aes_pkg::aes_cmd_t                    cmd,
  output logic [$clog2(4*(NUM_ROUNDS+1))-1:0]  kx_idx,
  output logic [$clog2(NUM_ROUNDS+1)-1:0]      rk_sel
);

  localparam int NumWords = 4 * (NUM_ROUNDS + 1);
  localparam int WordIdxW = $clog2(NumWords);
  localparam int RoundW   = $clog2(NUM_ROUNDS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;

  logic [2:0]          fsm, fsm_next;
  logic [RoundW-1:0]   rnd, rnd_next;
  logic [WordIdxW-1:0] kx_next;
  logic                dec;
  logic                kx_pend;

  // rk_sel is the round whose key the registered read presents next cycle.
  always_comb begin
    fsm_next = fsm;
    rnd_next = rnd;
    kx_next  = kx_idx;
    cmd      = '0;
    rk_sel   = rnd;
    in_ready = 1'b0;
    case (fsm)
      S_IDLE: begin
        in_ready = !kx_pend;
        rk_sel   = (in_command == aes_pkg::CMD_DECRYPT) ? RoundW'(NUM_ROUNDS) : '0;
        if (kx_pend) begin
          cmd.kx_start = 1'b1;
          kx_next  = WordIdxW'(4);
          fsm_next = S_KEY;
        end else if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          fsm_next = S_FIRST;
        end
      end
      S_KEY: begin
        cmd.kx_step = 1'b1;
        kx_next = kx_idx + WordIdxW'(1);
        if (kx_idx == WordIdxW'(NumWords - 1)) fsm_next = S_IDLE;
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        rnd_next = dec ? RoundW'(NUM_ROUNDS - 1) : RoundW'(1);
        rk_sel   = rnd_next;
        fsm_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_next = dec ? rnd - RoundW'(1) : rnd + RoundW'(1);
        rk_sel   = rnd_next;
        if ((dec && rnd == RoundW'(1)) || (!dec && rnd == RoundW'(NUM_ROUNDS - 1)))
          fsm_next = S_LAST;
      end
      S_LAST: begin
        // Final round waits while the previous result is still unread.
        if (!out_valid || out_ready) begin
          cmd.last = 1'b1;
          fsm_next = S_IDLE;
        end
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      rnd       <= '0;
      kx_idx    <= '0;
      dec       <= 1'b0;
      kx_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fsm    <= fsm_next;
      rnd    <= rnd_next;
      kx_idx <= kx_next;
      if (key_write) kx_pend <= 1'b1;
      else if (cmd.kx_start) kx_pend <= 1'b0;
      if (cmd.load) dec <= in_command;
      if (cmd.last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `AES_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, fsm == S_IDLE && !kx_pend, "ready while busy")
  `AES_ASSERT_NEXT(a_last_valid, clk, rst, cmd.last, out_valid, "result not shown after last round")
  `AES_ASSERT_IMP(a_last_free, clk, rst, cmd.last, !out_valid || out_ready, "result overwritten")
  `AES_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "datapath commands overlap")
  `AES_ASSERT_IMP(a_rnd_range, clk, rst, fsm == S_ROUND, rnd != '0 && rnd < RoundW'(NUM_ROUNDS), "round out of range")

endmodule

// ===== rtl/aes128_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher_core
// AES-128 ECB encrypt/decrypt with an APB key port.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      command, block_high, block_low
//  out_ch    out   valid/ready      result_high, result_low
//  apb       in    psel/penable     key_high @0x0, key_low @0x8
//
//  A request is loaded at its accept edge; the result is valid after one
//  first-key add, nine middle rounds and one final round on one round
//  unit, and no new request is taken before its final round. The result
//  sits in its own register; an unread result stalls only the final round.
//  A key write starts an expansion, one round-key word per cycle; requests
//  wait until it is done. Reset clears control state and key registers.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core #(
  parameter int NUM_ROUNDS = aes_pkg::NumRounds
) (
  input  logic        clk,
  input  logic        rst,
  aes_in_if.sink      in_ch,
  aes_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int WordIdxW = $clog2(4 * (NUM_ROUNDS + 1));
  localparam int RoundW   = $clog2(NUM_ROUNDS + 1);
  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

  logic [63:0] key_high, key_low;
  logic        wr, key_write;
  aes_pkg::aes_cmd_t         cmd;
  logic [WordIdxW-1:0]       kx_idx;
  logic [RoundW-1:0]         rk_sel;
  logic [127:0]              result;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign key_write = wr && (paddr == ADDR_KEY_HIGH || paddr == ADDR_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr) begin
      if (paddr == ADDR_KEY_HIGH) key_high <= pwdata;
      if (paddr == ADDR_KEY_LOW)  key_low  <= pwdata;
    end
  end

  always_comb begin
    case (paddr)
      ADDR_KEY_HIGH: prdata = key_high;
      ADDR_KEY_LOW:  prdata = key_low;
      default:       prdata = '0;
    endcase
  end

  aes_ctrl #(.NUM_ROUNDS(NUM_ROUNDS)) u_ctrl (
    .clk, .rst, .key_write,
    .in_valid(in_ch.valid), .in_command(in_ch.command), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .kx_idx, .rk_sel
  );

  aes_datapath #(.NUM_ROUNDS(NUM_ROUNDS)) u_dp (
    .clk, .cmd, .command(in_ch.command),
    .block_in({in_ch.block_high, in_ch.block_low}), .key_in({key_high, key_low}),
    .kx_idx, .rk_sel, .result
  );

  assign out_ch.result_high = result[127:64];
  assign out_ch.result_low  = result[63:0];

endmodule
